@@ hw/rtl/sharp3_pkg.sv @@
// ============================================================================
// sharp3_pkg
// Shared types and constants for the 3x3 sharpening filter.
// ============================================================================
package sharp3_pkg;

    localparam int PIX_W        = 8;
    localparam int COORD_W      = 7;
    localparam int SUM_W        = 13;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int COLSUM_W     = 10;
    localparam int SHARP3_MAX_WIDTH = 128;
    localparam int MAX_HEIGHT   = 128;
    localparam int MIN_DIM      = 3;
    localparam int DIM_RESET    = 128;

    typedef logic [PIX_W-1:0] t_pix;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // per-beat control carried down the pipe
    typedef struct packed {
        logic               prod;       // beat yields a result
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } t_info;

endpackage

@@ hw/rtl/sharp3_line_buf.sv @@
// ============================================================================
// sharp3_line_buf
// Two-row line store, one word per column holding {older row, newer row}.
// ============================================================================
module sharp3_line_buf #(
    parameter int DEPTH = sharp3_pkg::SHARP3_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [2*sharp3_pkg::PIX_W-1:0] i_wr_data,
    output logic [2*sharp3_pkg::PIX_W-1:0] o_rd_data
);
    import sharp3_pkg::*;

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/sharp3_win_cell.sv @@
// ============================================================================
// sharp3_win_cell
// One column of the 3x3 window; shifts toward its left neighbor on i_shift.
// ============================================================================
module sharp3_win_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  sharp3_pkg::t_pix              i_top,
    input  sharp3_pkg::t_pix              i_mid,
    input  sharp3_pkg::t_pix              i_bot,
    output sharp3_pkg::t_pix              o_top,
    output sharp3_pkg::t_pix              o_mid,
    output sharp3_pkg::t_pix              o_bot,
    output logic [sharp3_pkg::COLSUM_W-1:0] o_col_sum
);
    import sharp3_pkg::*;

    t_pix r_top;
    t_pix r_mid;
    t_pix r_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_mid <= '0;
            r_bot <= '0;
        end else if (i_shift) begin
            r_top <= i_top;
            r_mid <= i_mid;
            r_bot <= i_bot;
        end
    end

    assign o_top     = r_top;
    assign o_mid     = r_mid;
    assign o_bot     = r_bot;
    assign o_col_sum = COLSUM_W'(r_top) + COLSUM_W'(r_mid) + COLSUM_W'(r_bot);

endmodule

@@ hw/rtl/sharpen_3x3_convolution.sv @@
// ============================================================================
// sharpen_3x3_convolution
// 3x3 sharpen filter (9*center - 8 neighbors) on an 8-bit raster stream.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | i_valid / o_stall     | i_pixel, i_frame_start
//  out     | o_valid / i_stall     | o_sharpened, o_out_row, o_out_col, o_frame_end
//  cfg     | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
//  One pixel beat per clock sustained while no stall holds the pipe.
//  The line store read (registered, one port each for read and write) sets the
//  first stage; the window chain and the output register follow.
//  Reset clears counters, valid bits, window and config (128 x 128); the line
//  store is not cleared and needs no sweep.
//  i_stall holds the output register; earlier stages keep filling until full,
//  then o_stall rises.
//
module sharpen_3x3_convolution #(
    parameter int MAX_WIDTH = sharp3_pkg::SHARP3_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sharp3_pkg::PIX_W-1:0]      i_pixel,
    input  logic                              i_frame_start,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [sharp3_pkg::SUM_W-1:0] o_sharpened,
    output logic [sharp3_pkg::COORD_W-1:0]    o_out_row,
    output logic [sharp3_pkg::COORD_W-1:0]    o_out_col,
    output logic                              o_frame_end,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sharp3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sharp3_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import sharp3_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW1  = $clog2(MAX_WIDTH + 1);
    localparam int WW   = (CW1 > CFG_W) ? CW1 : CFG_W;   // column math width
    localparam int RW   = COORD_W + 1;                     // row math width

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= CFG_W'(DIM_RESET);
            r_frame_height <= CFG_W'(DIM_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage handshakes ----------------
    logic   r_s1_valid;
    logic   r_s2_valid;
    logic   r_o_valid;
    t_info  r_s1_info;
    t_info  r_s2_info;
    logic   out_free;
    logic   s2_move;
    logic   s2_free;
    logic   s1_move;
    logic   s1_free;
    logic   accept;

    assign out_free = !r_o_valid || !i_stall;
    assign s2_move  = r_s2_valid && (!r_s2_info.prod || out_free);
    assign s2_free  = !r_s2_valid || s2_move;
    assign s1_move  = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign accept   = i_valid && s1_free;
    assign o_stall  = !s1_free;

    // ---------------- raster counters ----------------
    logic [COORD_W-1:0] r_row;
    logic [AW-1:0]      r_col;
    logic [WW-1:0]      w_lim;
    logic [RW-1:0]      h_lim;
    logic [WW-1:0]      cur_col;
    logic [RW-1:0]      cur_row;
    logic [WW-1:0]      nxt_col;
    logic [RW-1:0]      nxt_row;
    t_info              s0_info;

    always_comb begin
        logic [WW-1:0] lw;
        logic [RW-1:0] fh;
        lw = WW'(r_line_width);
        fh = RW'(r_frame_height);
        // out-of-range settings saturate
        if (lw < WW'(MIN_DIM))          w_lim = WW'(MIN_DIM);
        else if (lw > WW'(MAX_WIDTH))   w_lim = WW'(MAX_WIDTH);
        else                            w_lim = lw;
        if (fh < RW'(MIN_DIM))          h_lim = RW'(MIN_DIM);
        else if (fh > RW'(MAX_HEIGHT))  h_lim = RW'(MAX_HEIGHT);
        else                            h_lim = fh;

        // position of this beat; wrap first in case a limit shrank
        cur_col = i_frame_start ? '0 : WW'(r_col);
        cur_row = i_frame_start ? '0 : RW'(r_row);
        if (cur_col >= w_lim) begin
            cur_col = '0;
            cur_row = cur_row + RW'(1);
        end
        if (cur_row >= h_lim) begin
            cur_row = '0;
        end

        nxt_col = cur_col + WW'(1);
        nxt_row = cur_row;
        if (nxt_col >= w_lim) begin
            nxt_col = '0;
            nxt_row = cur_row + RW'(1);
            if (nxt_row >= h_lim) begin
                nxt_row = '0;
            end
        end

        s0_info.prod      = (cur_row >= RW'(2)) && (cur_col >= WW'(2));
        s0_info.row       = COORD_W'(cur_row - RW'(1));
        s0_info.col       = COORD_W'(cur_col - WW'(1));
        s0_info.frame_end = (cur_row == h_lim - RW'(1)) && (cur_col == w_lim - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= nxt_row[COORD_W-1:0];
            r_col <= nxt_col[AW-1:0];
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       r_s1_addr;
    t_pix                r_s1_px;
    logic [2*PIX_W-1:0]  lb_rd_data;
    logic [2*PIX_W-1:0]  s1_lines;      // {older row, newer row} at this column
    logic [2*PIX_W-1:0]  lb_wr_data;
    logic                r_fwd;
    logic [2*PIX_W-1:0]  r_fwd_data;

    assign rd_addr    = cur_col[AW-1:0];
    // a column re-read right behind its own write (frame restart) takes the
    // write data instead of the stale memory word
    assign s1_lines   = r_fwd ? r_fwd_data : lb_rd_data;
    assign lb_wr_data = {s1_lines[PIX_W-1:0], r_s1_px};

    sharp3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (lb_wr_data),
        .o_rd_data (lb_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= rd_addr;
            r_s1_px    <= i_pixel;
            r_s1_info  <= s0_info;
            r_fwd      <= s1_move && (r_s1_addr == rd_addr);
            r_fwd_data <= lb_wr_data;
        end
    end

    // ---------------- stage 2: window chain ----------------
    t_pix                cell_top [3];
    t_pix                cell_mid [3];
    t_pix                cell_bot [3];
    logic [COLSUM_W-1:0] cell_sum [3];

    // rightmost cell takes the new column; each cell feeds its left neighbor
    sharp3_win_cell u_cell_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (s1_move),
        .i_top     (s1_lines[2*PIX_W-1:PIX_W]),
        .i_mid     (s1_lines[PIX_W-1:0]),
        .i_bot     (r_s1_px),
        .o_top     (cell_top[2]),
        .o_mid     (cell_mid[2]),
        .o_bot     (cell_bot[2]),
        .o_col_sum (cell_sum[2])
    );

    for (genvar g = 0; g < 2; g++) begin : g_cell
        sharp3_win_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (s1_move),
            .i_top     (cell_top[g+1]),
            .i_mid     (cell_mid[g+1]),
            .i_bot     (cell_bot[g+1]),
            .o_top     (cell_top[g]),
            .o_mid     (cell_mid[g]),
            .o_bot     (cell_bot[g]),
            .o_col_sum (cell_sum[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_info <= r_s1_info;
        end
    end

    // ---------------- output: 10*center - sum of all nine ----------------
    logic signed [SUM_W-1:0] n_sharp;
    logic signed [SUM_W-1:0] r_sharp;
    t_info                   r_o_info;

    always_comb begin
        logic [SUM_W-2:0] ctr10;
        logic [SUM_W-2:0] total;
        ctr10 = ((SUM_W-1)'(cell_mid[1]) << 3) + ((SUM_W-1)'(cell_mid[1]) << 1);
        total = (SUM_W-1)'(cell_sum[0]) + (SUM_W-1)'(cell_sum[1])
              + (SUM_W-1)'(cell_sum[2]);
        n_sharp = $signed({1'b0, ctr10}) - $signed({1'b0, total});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s2_move && r_s2_info.prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s2_move && r_s2_info.prod) begin
            r_sharp  <= n_sharp;
            r_o_info <= r_s2_info;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_sharpened = r_sharp;
    assign o_out_row   = r_o_info.row;
    assign o_out_col   = r_o_info.col;
    assign o_frame_end = r_o_info.frame_end;

endmodule

@@ hw/rtl/sharp3_checker.sv @@
// ============================================================================
// sharp3_checker
// Port-level checks for the sharpen filter, bound to the top level.
// ============================================================================
module sharp3_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [sharp3_pkg::SUM_W-1:0] o_sharpened,
    input logic [sharp3_pkg::COORD_W-1:0]    o_out_row,
    input logic [sharp3_pkg::COORD_W-1:0]    o_out_col,
    input logic                              o_frame_end
);
    import sharp3_pkg::*;

    // stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sharpened) && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_frame_end))
        else $error("result beat changed while stalled");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // no result ever carries row or column 0 or the all-ones row or column
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_row != '0) && (o_out_col != '0)
            && (o_out_row != '1) && (o_out_col != '1))
        else $error("result for a border pixel");

    // 9*center - neighbors of 8-bit pixels stays in [-2040, 2295]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sharpened >= -13'sd2040) && (o_sharpened <= 13'sd2295))
        else $error("sharpened value out of range");

endmodule

bind sharpen_3x3_convolution sharp3_checker u_sharp3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_sharpened (o_sharpened),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_frame_end (o_frame_end)
);

@@ verif/sharpen_3x3_convolution_checker.sv @@
// ============================================================================
// sharpen_3x3_convolution_checker
// Watches the pixel, result and register ports of the sharpen filter, keeps
// its own copy of the line stores, window and counters, and checks every
// result beat against the predicted one in arrival order.
// ============================================================================
module sharpen_3x3_convolution_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pixel channel
    input  logic                                  i_pix_valid,
    input  logic                                  i_pix_stall,
    input  sharp3_pkg::t_pix                      i_pixel,
    input  logic                                  i_frame_start,
    // result channel
    input  logic                                  i_res_valid,
    input  logic                                  i_res_stall,
    input  logic signed [sharp3_pkg::SUM_W-1:0]   i_sharpened,
    input  logic [sharp3_pkg::COORD_W-1:0]        i_out_row,
    input  logic [sharp3_pkg::COORD_W-1:0]        i_out_col,
    input  logic                                  i_frame_end,
    // register writes
    input  logic                                  i_cfg_we,
    input  logic [sharp3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sharp3_pkg::CFG_W-1:0]          i_cfg_wdata,
    // status for the test
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sharp3_pkg::*;

    localparam int CENTER_GAIN = 9;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SUM_W-1:0] sharp;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      col;
        logic                    fend;
    } t_sharp_result;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_pix             older_row [SHARP3_MAX_WIDTH];  // two rows up
    t_pix             newer_row [SHARP3_MAX_WIDTH];  // one row up
    t_pix             win [9];                       // 3x3, row-major, col 2 newest
    int               row_cnt;
    int               col_cnt;
    t_sharp_result    sharpened_q [$];
    int               fail_cnt = 0;

    function automatic int dim_in_use(logic [CFG_W-1:0] v, int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    task automatic clear_filter();
        width_reg  = CFG_W'(DIM_RESET);
        height_reg = CFG_W'(DIM_RESET);
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        row_cnt = 0;
        col_cnt = 0;
        sharpened_q.delete();
    endtask

    // one accepted pixel: advance counters, line stores and window; queue a
    // result when the window covers an interior pixel
    task automatic take_pixel(t_pix px, logic fs);
        int            w;
        int            h;
        int            col;
        int            sum;
        int            r;
        int            k;
        t_pix          top;
        t_pix          mid;
        t_sharp_result res;
        w = dim_in_use(width_reg, SHARP3_MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        if (fs) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        // a shrunk limit takes effect at once
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        col = (col_cnt >= SHARP3_MAX_WIDTH) ? SHARP3_MAX_WIDTH - 1 : col_cnt;

        top = older_row[col];
        mid = newer_row[col];
        older_row[col] = mid;
        newer_row[col] = px;

        for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;

        if (row_cnt >= 2 && col_cnt >= 2) begin
            sum = 0;
            for (k = 0; k < 9; k++) begin
                if (k == 4) sum += CENTER_GAIN * int'(win[k]);
                else sum -= int'(win[k]);
            end
            res.sharp = SUM_W'(sum);
            res.row   = COORD_W'(row_cnt - 1);
            res.col   = COORD_W'(col_cnt - 1);
            res.fend  = (row_cnt == h - 1) && (col_cnt == w - 1);
            sharpened_q.push_back(res);
        end

        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
    endtask

    task automatic log_failure(string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_sharp_result want;
        if (!i_rst_n) begin
            clear_filter();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LINE_WIDTH:   width_reg  = i_cfg_wdata;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // a result always leaves later than its pixel, so check before predicting
            if (i_res_valid && !i_res_stall) begin
                if (sharpened_q.size() == 0) begin
                    log_failure($sformatf(
                        "%0t: result beat with nothing expected: %0d r%0d c%0d e%0b",
                        $time, i_sharpened, i_out_row, i_out_col, i_frame_end));
                end else begin
                    want = sharpened_q.pop_front();
                    if (i_sharpened !== want.sharp || i_out_row !== want.row ||
                        i_out_col !== want.col || i_frame_end !== want.fend) begin
                        log_failure($sformatf(
                            "%0t: expected %0d r%0d c%0d e%0b, got %0d r%0d c%0d e%0b",
                            $time, want.sharp, want.row, want.col, want.fend,
                            i_sharpened, i_out_row, i_out_col, i_frame_end));
                    end
                end
            end
            if (i_pix_valid && !i_pix_stall) take_pixel(i_pixel, i_frame_start);
        end
        o_pending    <= sharpened_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

@@ verif/sharpen_3x3_convolution_tb.sv @@
// ============================================================================
// sharpen_3x3_convolution_tb
// Drives pixel frames of many sizes into the sharpen filter with random gaps
// and output stalls; the checker beside the block predicts and compares.
// ============================================================================
module sharpen_3x3_convolution_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sharp3_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEM_TARGET    = 1100;
    localparam int DRAIN_CYCLES   = 8;     // result passes the stage-1, window and output registers
    localparam int WATCHDOG_LIMIT = 2000;  // outlasts the longest output stall run
    localparam int FRAME_CAP      = 150;   // keep tall random frames short

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_stall;
    t_pix                      i_pixel       = '0;
    logic                      i_frame_start = 1'b0;
    logic                      o_valid;
    logic                      i_stall       = 1'b0;
    logic signed [SUM_W-1:0]   o_sharpened;
    logic [COORD_W-1:0]        o_out_row;
    logic [COORD_W-1:0]        o_out_col;
    logic                      o_frame_end;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx     = '0;
    logic [CFG_W-1:0]          i_cfg_wdata   = '0;

    int          fail_count;
    int          pending;
    int unsigned items_sent   = 0;
    int unsigned dim_w        = DIM_RESET;  // limits in use, after saturation
    int unsigned dim_h        = DIM_RESET;
    bit          tx_steady    = 1'b0;       // sender runs with no gaps
    int unsigned rx_left      = 0;
    int unsigned quiet_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    sharpen_3x3_convolution dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sharpened   (o_sharpened),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_frame_end   (o_frame_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    sharpen_3x3_convolution_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_sharpened   (o_sharpened),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_frame_end   (o_frame_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // pixel values lean on the rails so the sum hits its extremes
    function automatic t_pix pick_pixel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return t_pix'($urandom_range(255));
    endfunction

    // raw register value: mostly small frames, some out of range both ways
    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return CFG_W'($urandom_range(0, MIN_DIM - 1));
        if (r < 70) return CFG_W'($urandom_range(MIN_DIM, 8));
        if (r < 90) return CFG_W'($urandom_range(9, 24));
        return CFG_W'($urandom_range(MAX_HEIGHT + 1, 255));
    endfunction

    function automatic int unsigned dim_in_use(logic [CFG_W-1:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > SHARP3_MAX_WIDTH) return SHARP3_MAX_WIDTH;
        return 32'(v);
    endfunction

    // output side: stall runs of random length, and long stretches with none
    always @(posedge i_clk) begin : rx_stall_gen
        int unsigned len;
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            rx_left <= ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(15);
        end else begin
            len = pick_gap();
            if (len != 0) begin
                i_stall <= 1'b1;
                rx_left <= len - 1;
            end
        end
    end

    // watchdog: too long with no beat on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one pixel beat; valid stays up between back-to-back beats
    task automatic send_beat(t_pix px, logic fs);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // a run of random pixels; noisy runs scatter frame starts mid-frame
    task automatic send_run(int unsigned n, bit first_fs, bit noisy);
        logic fs;
        for (int unsigned i = 0; i < n; i++) begin
            fs = (i == 0) ? first_fs : (noisy && $urandom_range(4) == 0);
            send_beat(pick_pixel(), fs);
        end
    endtask

    // hold the sender until every expected result is out, then let the
    // pipe empty of beats that give no result
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register writes only with the block idle
    task automatic write_dims(bit do_w, logic [CFG_W-1:0] w, bit do_h, logic [CFG_W-1:0] h);
        drain();
        if (do_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_LINE_WIDTH;
            i_cfg_wdata <= w;
            @(posedge i_clk);
            dim_w = dim_in_use(w);
        end
        if (do_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_FRAME_HEIGHT;
            i_cfg_wdata <= h;
            @(posedge i_clk);
            dim_h = dim_in_use(h);
        end
        i_cfg_we <= 1'b0;
    endtask

    // one random phase: maybe new limits, then a few frames. Phases that
    // skip the frame start carry on from where the counters stand, so a
    // limit change lands mid-frame.
    task automatic random_phase();
        bit          do_w;
        bit          do_h;
        int unsigned frames;
        int unsigned full;
        int unsigned kind;
        do_w = ($urandom_range(3) != 0);
        do_h = ($urandom_range(3) != 0);
        if (do_w || do_h) write_dims(do_w, pick_dim(), do_h, pick_dim());
        tx_steady = ($urandom_range(3) == 0);
        frames    = $urandom_range(1, 3);
        repeat (frames) begin
            if (items_sent >= ITEM_TARGET) break;
            full = dim_w * dim_h;
            if (full > FRAME_CAP) full = FRAME_CAP;
            kind = $urandom_range(9);
            if (kind < 6)
                send_run(full, 1'b1, 1'b0);                    // clean frame
            else if (kind == 6)
                send_run(full, 1'b0, 1'b0);                    // no frame start
            else if (kind == 7)
                send_run($urandom_range(1, full - 1), 1'b1, 1'b0); // cut short
            else
                send_run($urandom_range(1, 2 * dim_w), bit'($urandom_range(1)), 1'b1);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // three full 128-pixel rows at the reset limits: writes every line
        // store entry (no later read sees an unwritten one) and reaches the
        // rightmost column
        send_run(3 * dim_w, 1'b1, 1'b0);

        // directed: limits below range saturate to a 3x3 frame
        write_dims(1'b1, CFG_W'(0), 1'b1, CFG_W'(MIN_DIM - 1));
        tx_steady = 1'b1;
        // bright center on black: largest sum, frame end flagged
        for (int i = 0; i < 9; i++) send_beat((i == 4) ? '1 : '0, i == 0);
        // dark center on white, entered by running past the frame end
        for (int i = 0; i < 9; i++) send_beat((i == 4) ? '0 : '1, 1'b0);
        // one stray pixel, then a frame start in mid-frame
        send_beat(t_pix'(8'h5a), 1'b0);
        for (int i = 0; i < 9; i++) send_beat(pick_pixel(), i == 0);

        // narrowest and tallest frame (height above range saturates), plus
        // a few pixels into the next frame
        write_dims(1'b1, CFG_W'(MIN_DIM), 1'b1, CFG_W'(255));
        tx_steady = 1'b0;
        send_run(MIN_DIM * MAX_HEIGHT + MIN_DIM, 1'b1, 1'b0);

        while (items_sent < ITEM_TARGET) random_phase();

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
